// ===== hdl/ffdl_pkg.sv =====
package ffdl_pkg;

    localparam int SAMPLE_W      = 16;
    localparam int LINE_LENGTH_W = 13;
    localparam int DELAY_W       = 29;
    localparam int GAIN_W        = 16;
    localparam int CFG_INDEX_W   = 2;
    localparam int CFG_DATA_W    = 29;

    localparam logic [CFG_INDEX_W-1:0] REG_LINE_LENGTH   = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_DELAY_SAMPLES = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_FEEDBACK_GAIN = 2'd2;

    localparam logic [DELAY_W-1:0] DELAY_RESET = 29'd268369920;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_ADDR,
        ST_READ,
        ST_MUL1,
        ST_MUL2,
        ST_MUL3,
        ST_WB
    } ctrl_state_t;

    typedef struct packed {
        logic clear;
        logic accept;
        logic addr;
        logic rd;
        logic mul1;
        logic mul2;
        logic mul3;
        logic wb;
    } dp_cmd_t;

    typedef struct packed {
        logic clear_done;
        logic out_free;
    } dp_status_t;

    function automatic logic signed [SAMPLE_W-1:0] sat16(input logic signed [18:0] v);
        logic signed [SAMPLE_W-1:0] r;
        if (v > 19'sd32767)
        begin
            r = 16'sh7fff;
        end
        else if (v < -19'sd32768)
        begin
            r = 16'sh8000;
        end
        else
        begin
            r = v[SAMPLE_W-1:0];
        end
        return r;
    endfunction

endpackage

// ===== hdl/ffdl_ctrl.sv =====
module ffdl_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  ffdl_pkg::dp_status_t status,
    output ffdl_pkg::dp_cmd_t    cmd
);
    import ffdl_pkg::*;

    ctrl_state_t state_reg;
    ctrl_state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        s_ready    = 1'b0;
        case (state_reg)
            ST_CLEAR:
            begin
                cmd.clear = 1'b1;
                if (status.clear_done)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                s_ready = 1'b1;
                if (s_valid)
                begin
                    cmd.accept = 1'b1;
                    state_next = ST_ADDR;
                end
            end
            ST_ADDR:
            begin
                cmd.addr   = 1'b1;
                state_next = ST_READ;
            end
            ST_READ:
            begin
                cmd.rd     = 1'b1;
                state_next = ST_MUL1;
            end
            ST_MUL1:
            begin
                cmd.mul1   = 1'b1;
                state_next = ST_MUL2;
            end
            ST_MUL2:
            begin
                cmd.mul2   = 1'b1;
                state_next = ST_MUL3;
            end
            ST_MUL3:
            begin
                cmd.mul3   = 1'b1;
                state_next = ST_WB;
            end
            ST_WB:
            begin
                if (status.out_free)
                begin
                    cmd.wb     = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

// ===== hdl/ffdl_datapath.sv =====
module ffdl_datapath #(
    parameter int MAX_DEPTH = 4096,
    parameter int FRAC_BITS = 16
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  ffdl_pkg::dp_cmd_t                     cmd,
    output ffdl_pkg::dp_status_t                  status,
    input  logic                                  cfg_valid,
    input  logic [ffdl_pkg::CFG_INDEX_W-1:0]      cfg_index,
    input  logic [ffdl_pkg::CFG_DATA_W-1:0]       cfg_data,
    input  logic [ffdl_pkg::SAMPLE_W-1:0]         s_data,
    output logic                                  m_valid,
    input  logic                                  m_ready,
    output logic [ffdl_pkg::SAMPLE_W-1:0]         m_data
);
    import ffdl_pkg::*;

    localparam int ADDR_W   = $clog2(MAX_DEPTH);
    localparam int LEN_W    = $clog2(MAX_DEPTH + 1);
    localparam int LF_W     = LEN_W + FRAC_BITS;
    localparam int CW       = (LEN_W > LINE_LENGTH_W) ? LEN_W : LINE_LENGTH_W;
    localparam int DCW      = (LF_W > DELAY_W) ? LF_W : DELAY_W;
    localparam int PW       = FRAC_BITS + 18;
    localparam int LL_RESET = (MAX_DEPTH > 8191) ? 8191 : MAX_DEPTH;
    localparam logic signed [PW-1:0] HALF = PW'(1) << (FRAC_BITS - 1);

    logic [SAMPLE_W-1:0] line_mem [MAX_DEPTH];

    logic [LINE_LENGTH_W-1:0] line_length_reg;
    logic [DELAY_W-1:0]       delay_reg;
    logic signed [GAIN_W-1:0] gain_reg;
    logic [ADDR_W-1:0]        wp_reg;
    logic [ADDR_W-1:0]        clr_cnt_reg;
    logic                     out_valid_reg;

    logic [LEN_W-1:0]            len_reg;
    logic [ADDR_W-1:0]           wpe_reg;
    logic [LF_W-1:0]             lenf_reg;
    logic [LF_W-1:0]             dcl_reg;
    logic signed [SAMPLE_W-1:0]  sin_reg;
    logic [LF_W:0]               pos_raw_reg;
    logic signed [SAMPLE_W-1:0]  si_reg;
    logic signed [SAMPLE_W-1:0]  sj_reg;
    logic [FRAC_BITS-1:0]        f_reg;
    logic signed [PW-1:0]        prod_reg;
    logic signed [SAMPLE_W-1:0]  o_reg;
    logic signed [31:0]          fbp_reg;
    logic [SAMPLE_W-1:0]         out_data_reg;

    logic [CW-1:0]              ll_ext;
    logic [LEN_W-1:0]           len_c;
    logic [ADDR_W-1:0]          wp_c;
    logic [LF_W-1:0]            lenf_c;
    logic [LF_W-1:0]            dcl_c;
    logic [LF_W:0]              pos_raw_c;
    logic [LF_W-1:0]            pos_w;
    logic [ADDR_W-1:0]          ri;
    logic [LEN_W-1:0]           rj_sum;
    logic [ADDR_W-1:0]          rj;
    logic signed [16:0]         diff;
    logic signed [PW-1:0]       rnd_full;
    logic signed [18:0]         o_sum;
    logic signed [32:0]         fb_full;
    logic signed [18:0]         st_sum;
    logic signed [SAMPLE_W-1:0] st;
    logic [LEN_W-1:0]           wp_inc;
    logic [ADDR_W-1:0]          wp_adv;

    // length and delay clamping at accept
    always_comb
    begin
        ll_ext = CW'(line_length_reg);
        if (ll_ext == '0)
        begin
            len_c = LEN_W'(1);
        end
        else if (ll_ext > CW'(MAX_DEPTH))
        begin
            len_c = LEN_W'(MAX_DEPTH);
        end
        else
        begin
            len_c = LEN_W'(ll_ext);
        end
        wp_c   = (LEN_W'(wp_reg) >= len_c) ? '0 : wp_reg;
        lenf_c = {len_c, {FRAC_BITS{1'b0}}};
        dcl_c  = (DCW'(delay_reg) > DCW'(lenf_c)) ? lenf_c : LF_W'(delay_reg);
    end

    assign pos_raw_c = (LF_W+1)'({wpe_reg, {FRAC_BITS{1'b0}}}) + (LF_W+1)'(lenf_reg)
                     - (LF_W+1)'(dcl_reg);

    // read addresses
    always_comb
    begin
        pos_w  = (pos_raw_reg >= (LF_W+1)'(lenf_reg)) ? LF_W'(pos_raw_reg - (LF_W+1)'(lenf_reg))
                                                      : LF_W'(pos_raw_reg);
        ri     = pos_w[FRAC_BITS +: ADDR_W];
        rj_sum = LEN_W'(ri) + LEN_W'(1);
        rj     = (rj_sum >= len_reg) ? '0 : ADDR_W'(rj_sum);
    end

    // interpolation and feedback
    always_comb
    begin
        diff     = 17'(sj_reg) - 17'(si_reg);
        rnd_full = (prod_reg + HALF) >>> FRAC_BITS;
        o_sum    = 19'(si_reg) + 19'($signed(rnd_full[17:0]));
        fb_full  = (33'(fbp_reg) + 33'sd16384) >>> 15;
        st_sum   = 19'(sin_reg) + 19'($signed(fb_full[17:0]));
        st       = sat16(st_sum);
        wp_inc   = LEN_W'(wpe_reg) + LEN_W'(1);
        wp_adv   = (wp_inc >= len_reg) ? '0 : ADDR_W'(wp_inc);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            line_length_reg <= LINE_LENGTH_W'(LL_RESET);
            delay_reg       <= DELAY_RESET;
            gain_reg        <= '0;
            wp_reg          <= '0;
            clr_cnt_reg     <= '0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            if (cfg_valid)
            begin
                case (cfg_index)
                    REG_LINE_LENGTH:   line_length_reg <= cfg_data[LINE_LENGTH_W-1:0];
                    REG_DELAY_SAMPLES: delay_reg       <= cfg_data[DELAY_W-1:0];
                    REG_FEEDBACK_GAIN: gain_reg        <= cfg_data[GAIN_W-1:0];
                    default:           ;
                endcase
            end
            if (cmd.clear)
            begin
                clr_cnt_reg <= clr_cnt_reg + ADDR_W'(1);
            end
            if (cmd.wb)
            begin
                wp_reg        <= wp_adv;
                out_valid_reg <= 1'b1;
            end
            else if (m_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.clear)
        begin
            line_mem[clr_cnt_reg] <= '0;
        end
        else if (cmd.wb)
        begin
            line_mem[wpe_reg] <= st;
        end
        if (cmd.rd)
        begin
            si_reg <= line_mem[ri];
            sj_reg <= line_mem[rj];
            f_reg  <= pos_w[FRAC_BITS-1:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            len_reg  <= len_c;
            wpe_reg  <= wp_c;
            lenf_reg <= lenf_c;
            dcl_reg  <= dcl_c;
            sin_reg  <= s_data;
        end
        if (cmd.addr)
        begin
            pos_raw_reg <= pos_raw_c;
        end
        if (cmd.mul1)
        begin
            prod_reg <= PW'(diff) * PW'($signed({1'b0, f_reg}));
        end
        if (cmd.mul2)
        begin
            o_reg <= sat16(o_sum);
        end
        if (cmd.mul3)
        begin
            fbp_reg <= gain_reg * o_reg;
        end
        if (cmd.wb)
        begin
            out_data_reg <= o_reg;
        end
    end

    assign status.clear_done = (clr_cnt_reg == ADDR_W'(MAX_DEPTH - 1));
    assign status.out_free   = !out_valid_reg || m_ready;
    assign m_valid           = out_valid_reg;
    assign m_data            = out_data_reg;

endmodule

// ===== hdl/fractional_feedback_delay_line.sv =====
// Fractional feedback delay line, Q1.15 audio.
// s_axis: one input sample per transaction, m_axis: one delayed sample per
// transaction, strictly in input order. cfg: register writes (index 0 line
// length, 1 delay in samples with FRAC_BITS fraction bits, 2 feedback gain),
// always ready; write only while no sample is in flight.
// After reset the line store is swept to zero, one entry per cycle, over
// all MAX_DEPTH entries (4096 by default); s_axis_tready stays low meanwhile.
// Each sample runs through a fixed sequence: clamp, address, two-port read,
// interpolation multiply, rounding, feedback multiply, write-back. Result
// valid is set at write-back; a new sample is accepted only after the
// previous write-back: a single sequencer shares the read/multiply path.
// The output register holds a result while m_axis_tready is low; the next
// input is still taken, but its write-back waits until the output is free.
module fractional_feedback_delay_line #(
    parameter int MAX_DEPTH = 4096,
    parameter int FRAC_BITS = 16
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  cfg_valid,
    output logic                                  cfg_ready,
    input  logic [ffdl_pkg::CFG_INDEX_W-1:0]      cfg_index,
    input  logic [ffdl_pkg::CFG_DATA_W-1:0]       cfg_data,
    input  logic                                  s_axis_tvalid,
    output logic                                  s_axis_tready,
    input  logic [ffdl_pkg::SAMPLE_W-1:0]         s_axis_tdata,  // [15:0] sample_in
    output logic                                  m_axis_tvalid,
    input  logic                                  m_axis_tready,
    output logic [ffdl_pkg::SAMPLE_W-1:0]         m_axis_tdata   // [15:0] sample_out
);
    import ffdl_pkg::*;

    dp_cmd_t    cmd;
    dp_status_t status;

    assign cfg_ready = 1'b1;

    ffdl_ctrl u_ctrl (
        .clk     (clk),
        .rst_n   (rst_n),
        .s_valid (s_axis_tvalid),
        .s_ready (s_axis_tready),
        .status  (status),
        .cmd     (cmd)
    );

    ffdl_datapath #(
        .MAX_DEPTH (MAX_DEPTH),
        .FRAC_BITS (FRAC_BITS)
    ) u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .status    (status),
        .cfg_valid (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_data    (s_axis_tdata),
        .m_valid   (m_axis_tvalid),
        .m_ready   (m_axis_tready),
        .m_data    (m_axis_tdata)
    );

`ifndef SYNTH
    a_wb_needs_free_output: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.wb |-> status.out_free)
        else $error("write-back with output register occupied");

    a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("second input accepted while a sample is in flight");

    a_result_from_wb: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_axis_tvalid) |-> $past(cmd.wb))
        else $error("output valid without write-back");

    a_no_input_in_clear: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.clear |-> !s_axis_tready)
        else $error("input ready during clearing pass");
`endif

endmodule
